[hdl/lwd_pkg.sv]
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared constants and types for the LZSS window decoder.
// ----------------------------------------------------------------------------
package lwd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 24;
  localparam int CNT_W        = LEN_W + 1;
  localparam int FLAG_W       = BYTE_W + 1;
  localparam int MATCH_MIN    = 3;
  localparam int REM_W        = 5;

  typedef logic [WIN_AW-1:0] win_addr_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Input word kinds
  typedef enum logic {OP_DATA = 1'b0, OP_NEW = 1'b1} op_t;

  localparam win_addr_t WRITE_START = win_addr_t'(12'hFEE);
  localparam win_addr_t WIN_LAST    = win_addr_t'(WINDOW_DEPTH - 1);

  // One cycle's access to the window memory
  typedef struct packed {
    logic      we;
    win_addr_t waddr;
    byte_t     wdata;
    logic      re;
    win_addr_t raddr;
  } ram_req_t;

endpackage

[hdl/lwd_intf.sv]
// ----------------------------------------------------------------------------
// lwd_intf
// Valid/ready channels for compressed input words and decoded output words.
// ----------------------------------------------------------------------------
interface lwd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [lwd_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface lwd_out_if;
  logic                         valid;
  logic                         ready;
  logic [lwd_pkg::BYTE_W-1:0]   out_byte;
  logic                         last;
  logic                         done_res;

  modport source (output valid, output out_byte, output last, output done_res,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input done_res,
                  output ready);
endinterface

[hdl/lwd_window_ram.sv]
// ----------------------------------------------------------------------------
// lwd_window_ram
// Sliding-window store: one write and one registered read per cycle. Read
// data holds while no read is issued; a read that hits the address written
// in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module lwd_window_ram (
  input  logic              clk,
  input  lwd_pkg::ram_req_t req,
  output lwd_pkg::byte_t    rdata
);

  lwd_pkg::byte_t mem [lwd_pkg::WINDOW_DEPTH];
  lwd_pkg::byte_t rd_r;
  lwd_pkg::byte_t fwd_data_r;
  logic           fwd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_r       <= mem[req.raddr];
      fwd_r      <= req.we && (req.waddr == req.raddr);
      fwd_data_r <= req.wdata;
    end
  end

  assign rdata = fwd_r ? fwd_data_r : rd_r;

endmodule

[hdl/lzss_window_decoder.sv]
// A literal word appears on the output in the cycle after it is taken.
// A match starts its copy in the cycle after its second word and then emits one
// byte per cycle while the output is not stalled (3 to 18 bytes), set by the
// single read port of the window. Flag words and first match words produce no
// output. Reset and a new-stream word start a clearing sweep of the window,
// one entry per cycle with the input held off; configuration is taken outside reset.
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS decompressor with a 4096-byte sliding window held in one memory.
// ----------------------------------------------------------------------------
module lzss_window_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  lwd_in_if.sink                      in_if,
  lwd_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic [lwd_pkg::LEN_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_COPY} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_MATCH} phase_t;

  state_t                       state_r, state_nxt;
  phase_t                       phase_r, phase_nxt;
  lwd_pkg::win_addr_t           clr_addr_r, clr_addr_nxt;
  lwd_pkg::win_addr_t           wpos_r, wpos_nxt;
  lwd_pkg::win_addr_t           src_r, src_nxt;
  logic [lwd_pkg::FLAG_W-1:0]   flag_r, flag_nxt;
  lwd_pkg::byte_t               mlow_r, mlow_nxt;
  logic [lwd_pkg::CNT_W-1:0]    ocount_r, ocount_nxt;
  logic [lwd_pkg::LEN_W-1:0]    olen_r;
  logic [lwd_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic                         out_valid_r, out_valid_nxt;
  lwd_pkg::byte_t               out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_done_r, out_done_nxt;

  lwd_pkg::ram_req_t            ram_req;
  lwd_pkg::byte_t               ram_rdata;

  logic                         out_free;
  logic                         in_ready;
  logic                         in_acc;
  logic                         emit;
  logic                         emit_last;
  lwd_pkg::byte_t               emit_byte;
  logic                         end_tok;
  logic [lwd_pkg::CNT_W-1:0]    cnt_inc;
  logic                         finished;
  lwd_pkg::win_addr_t           match_src;

  lwd_window_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_if.ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_if.valid && in_ready;
  assign cnt_inc   = ocount_r + lwd_pkg::CNT_W'(1);
  assign finished  = (phase_r != PH_MATCH) && (ocount_r >= {1'b0, olen_r});
  assign match_src = {in_if.in_byte[7:4], mlow_r};

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    clr_addr_nxt  = clr_addr_r;
    wpos_nxt      = wpos_r;
    src_nxt       = src_r;
    flag_nxt      = flag_r;
    mlow_nxt      = mlow_r;
    ocount_nxt    = ocount_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    ram_req       = '0;
    emit          = 1'b0;
    emit_last     = 1'b0;
    emit_byte     = '0;
    end_tok       = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr_r;
        clr_addr_nxt  = clr_addr_r + lwd_pkg::WIN_AW'(1);
        if (clr_addr_r == lwd_pkg::WIN_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_if.op == lwd_pkg::OP_NEW) begin
            state_nxt    = S_CLEAR;
            clr_addr_nxt = '0;
            wpos_nxt     = lwd_pkg::WRITE_START;
            flag_nxt     = '0;
            phase_nxt    = PH_FLAG;
            mlow_nxt     = '0;
            ocount_nxt   = '0;
          end else if (!finished) begin
            case (phase_r)
              PH_TOKEN: begin
                if (flag_r[0]) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  emit_byte = in_if.in_byte;
                  end_tok   = 1'b1;
                end else begin
                  mlow_nxt  = in_if.in_byte;
                  phase_nxt = PH_MATCH;
                end
              end
              PH_MATCH: begin
                // issue the first window read; the copy drains from it
                ram_req.re    = 1'b1;
                ram_req.raddr = match_src;
                src_nxt       = match_src + lwd_pkg::WIN_AW'(1);
                rem_nxt       = lwd_pkg::REM_W'(in_if.in_byte[3:0])
                              + lwd_pkg::REM_W'(lwd_pkg::MATCH_MIN);
                state_nxt     = S_COPY;
              end
              default: begin
                flag_nxt  = {1'b1, in_if.in_byte};
                phase_nxt = PH_TOKEN;
              end
            endcase
          end
        end
      end
      S_COPY: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = ram_rdata;
          emit_last = (rem_r == lwd_pkg::REM_W'(1));
          if (emit_last) begin
            state_nxt = S_IDLE;
            end_tok   = 1'b1;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = src_r;
            src_nxt       = src_r + lwd_pkg::WIN_AW'(1);
            rem_nxt       = rem_r - lwd_pkg::REM_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = wpos_r;
      ram_req.wdata = emit_byte;
      wpos_nxt      = wpos_r + lwd_pkg::WIN_AW'(1);
      ocount_nxt    = cnt_inc;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
      out_done_nxt  = (cnt_inc >= {1'b0, olen_r});
    end

    // advance to the next flag bit; fetch a new flag word when none remain
    if (end_tok) begin
      flag_nxt  = flag_r >> 1;
      phase_nxt = (flag_r[lwd_pkg::FLAG_W-1:2] == '0) ? PH_FLAG : PH_TOKEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_FLAG;
      clr_addr_r  <= '0;
      wpos_r      <= lwd_pkg::WRITE_START;
      src_r       <= '0;
      flag_r      <= '0;
      mlow_r      <= '0;
      ocount_r    <= '0;
      olen_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
      out_last_r  <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wpos_r      <= wpos_nxt;
      src_r       <= src_nxt;
      flag_r      <= flag_nxt;
      mlow_r      <= mlow_nxt;
      ocount_r    <= ocount_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      out_byte_r  <= out_byte_nxt;
      out_last_r  <= out_last_nxt;
      out_done_r  <= out_done_nxt;
      if (cfg_we) begin
        olen_r <= cfg_wdata;
      end
    end
  end

  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.last     = out_last_r;
  assign out_if.done_res = out_done_r;

endmodule

[hdl/lwd_checker.sv]
// ----------------------------------------------------------------------------
// lwd_checker
// Port-level checks for the LZSS window decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lwd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready
);

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // reset starts the window sweep: no input taken right after
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during window clear after reset");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present after reset");

  // a new-stream word starts a clearing sweep
  a_new_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("input ready right after new-stream word");

endmodule

bind lzss_window_decoder lwd_checker u_lwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_op     (in_if.op),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready)
);
